### hdl/ffba_pkg.sv
// ============================================================================
// ffba_pkg: shared types and constants of the first-fit block allocator
// Table geometry, field widths, item kinds, sequencer states and the
// write-port bundle that the controller hands to the block table.
// ============================================================================
package ffba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int USE_BITS   = $clog2(MAX_BLOCKS + 1);

  // Stream payload widths, bytes filled up with zeros.
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 40;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic CFG_WORD_BLOCKS_IN_USE = 1'b0;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 rem_we;
    logic                 orig_we;
    logic [IDX_BITS-1:0]  addr;
    logic [SIZE_BITS-1:0] rem_data;
    logic [SIZE_BITS-1:0] orig_data;
  } tbl_wr_t;

endpackage

### hdl/ffba_table.sv
// ============================================================================
// ffba_table: block table memory
// Holds the remaining and the original size of every block, one write
// port and one registered read port.
// ============================================================================
module ffba_table (
  input  logic                           clk,
  input  ffba_pkg::tbl_wr_t              wr,
  input  logic [ffba_pkg::IDX_BITS-1:0]  rd_addr,
  output logic [ffba_pkg::SIZE_BITS-1:0] rem_q,
  output logic [ffba_pkg::SIZE_BITS-1:0] orig_q
);

  logic [ffba_pkg::SIZE_BITS-1:0] rem_mem  [ffba_pkg::MAX_BLOCKS];
  logic [ffba_pkg::SIZE_BITS-1:0] orig_mem [ffba_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.rem_we) begin
      rem_mem[wr.addr] <= wr.rem_data;
    end
    if (wr.orig_we) begin
      orig_mem[wr.addr] <= wr.orig_data;
    end
    rem_q  <= rem_mem[rd_addr];
    orig_q <= orig_mem[rd_addr];
  end

endmodule

### hdl/ffba_fit_unit.sv
// ============================================================================
// ffba_fit_unit: shared fit check
// One subtractor compares a block's remaining size with the request and
// gives the size that would remain after a grant.
// ============================================================================
module ffba_fit_unit (
  input  logic [ffba_pkg::SIZE_BITS-1:0] remaining,
  input  logic [ffba_pkg::SIZE_BITS-1:0] request,
  output logic                           fits,
  output logic [ffba_pkg::SIZE_BITS-1:0] diff
);

  logic [ffba_pkg::SIZE_BITS:0] wide_diff;

  // The borrow bit is clear exactly when the block is large enough.
  assign wide_diff = {1'b0, remaining} - {1'b0, request};
  assign fits      = ~wide_diff[ffba_pkg::SIZE_BITS];
  assign diff      = wide_diff[ffba_pkg::SIZE_BITS-1:0];

endmodule

### hdl/first_fit_block_allocator_unit.sv
// Load transaction: the table is written at the accept edge.
// Allocate transaction: the scan compares blocks from index 0 upward, at most 16, then the result
// passes a pending register and the output register that drives out_tvalid. The single fit
// unit checks one block per cycle behind the table's registered read. No blocks in use: the
// request is refused without a scan. Input is not ready while a search runs or a finished
// result waits behind a held one. Sync reset clears state, rd_idx, cmp_vld, use_r, out_tvalid.
// ============================================================================
// first_fit_block_allocator_unit: first-fit memory block allocator
// Keeps a table of block sizes and grants each allocate request from the
// lowest-indexed block in use that still has room for it.
// ============================================================================
module first_fit_block_allocator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] block_index, [19:4] size_value, [23:20] zero
  input  logic [ffba_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [0] kind
  input  logic [0:0]                         in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] chosen_block, [19:4] block_capacity, [35:20] leftover, [39:36] zero
  output logic [ffba_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // [0] granted
  output logic [0:0]                         out_tuser,
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ffba_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [ffba_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [ffba_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                               cfg_pready
);

  localparam int IDX  = ffba_pkg::IDX_BITS;
  localparam int SZ   = ffba_pkg::SIZE_BITS;
  localparam int USE  = ffba_pkg::USE_BITS;

  // --------------------------------------------------------------------------
  // Configuration register. The word address is paddr[2]; the one register
  // sits in word zero and everything else reads as zero and ignores writes.
  // --------------------------------------------------------------------------
  logic [USE-1:0] use_r;
  logic           cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ffba_pkg::CFG_WORD_BLOCKS_IN_USE);
  assign cfg_prdata = cfg_hit ? {{(ffba_pkg::CFG_DATA_BITS - USE){1'b0}}, use_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      use_r <= cfg_pwdata[USE-1:0];
    end
  end

  // Values above the table depth search the whole table.
  logic [USE-1:0] limit;
  assign limit = (use_r > USE'(ffba_pkg::MAX_BLOCKS)) ? USE'(ffba_pkg::MAX_BLOCKS) : use_r;

  // --------------------------------------------------------------------------
  // Input fields.
  // --------------------------------------------------------------------------
  ffba_pkg::kind_t in_kind;
  logic [IDX-1:0]  in_index;
  logic [SZ-1:0]   in_size;
  logic            in_take;

  assign in_kind  = ffba_pkg::kind_t'(in_tuser[0]);
  assign in_index = in_tdata[IDX-1:0];
  assign in_size  = in_tdata[IDX +: SZ];
  assign in_take  = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Sequencer state.
  //   rd_idx_r  - next block address presented to the table
  //   cmp_idx_r - block whose sizes sit on the table's read outputs now
  //   cmp_vld_r - those outputs belong to a block in use and must be checked
  // --------------------------------------------------------------------------
  ffba_pkg::state_t state_r, state_nxt;
  logic [USE-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [USE-1:0]   limit_r, limit_nxt;
  logic [SZ-1:0]    req_r, req_nxt;

  // Finished result waiting for the output register.
  logic             pend_grant_r, pend_grant_nxt;
  logic [IDX-1:0]   pend_block_r, pend_block_nxt;
  logic [SZ-1:0]    pend_cap_r, pend_cap_nxt;
  logic [SZ-1:0]    pend_left_r, pend_left_nxt;

  // Output register.
  logic             out_vld_r, out_vld_nxt;
  logic             out_grant_r, out_grant_nxt;
  logic [IDX-1:0]   out_block_r, out_block_nxt;
  logic [SZ-1:0]    out_cap_r, out_cap_nxt;
  logic [SZ-1:0]    out_left_r, out_left_nxt;

  // Table and fit unit.
  ffba_pkg::tbl_wr_t tbl_wr;
  logic [SZ-1:0]     rem_q;
  logic [SZ-1:0]     orig_q;
  logic              fits;
  logic [SZ-1:0]     diff;

  ffba_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_idx_r[IDX-1:0]),
    .rem_q   (rem_q),
    .orig_q  (orig_q)
  );

  ffba_fit_unit u_fit (
    .remaining (rem_q),
    .request   (req_r),
    .fits      (fits),
    .diff      (diff)
  );

  logic fin_grant;
  logic fin_miss;
  logic out_free;

  assign fin_grant = cmp_vld_r && fits;
  assign fin_miss  = cmp_vld_r && !fits && (({1'b0, cmp_idx_r} + USE'(1)) == limit_r);
  assign out_free  = !out_vld_r || out_tready;

  assign in_tready = (state_r == ffba_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    limit_nxt      = limit_r;
    req_nxt        = req_r;
    pend_grant_nxt = pend_grant_r;
    pend_block_nxt = pend_block_r;
    pend_cap_nxt   = pend_cap_r;
    pend_left_nxt  = pend_left_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_grant_nxt  = out_grant_r;
    out_block_nxt  = out_block_r;
    out_cap_nxt    = out_cap_r;
    out_left_nxt   = out_left_r;
    tbl_wr         = '0;

    unique case (state_r)
      ffba_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_kind == ffba_pkg::KIND_LOAD) begin
            // A load sets capacity and free size together, no result.
            tbl_wr.rem_we    = 1'b1;
            tbl_wr.orig_we   = 1'b1;
            tbl_wr.addr      = in_index;
            tbl_wr.rem_data  = in_size;
            tbl_wr.orig_data = in_size;
          end else begin
            req_nxt     = in_size;
            limit_nxt   = limit;
            rd_idx_nxt  = '0;
            cmp_vld_nxt = 1'b0;
            if (limit == '0) begin
              // Nothing in use: refuse at once.
              pend_grant_nxt = 1'b0;
              pend_block_nxt = '0;
              pend_cap_nxt   = '0;
              pend_left_nxt  = '0;
              state_nxt      = ffba_pkg::ST_DONE;
            end else begin
              state_nxt = ffba_pkg::ST_SCAN;
            end
          end
        end
      end

      ffba_pkg::ST_SCAN: begin
        if (fin_grant) begin
          // First fit found: shrink the block and keep the result.
          tbl_wr.rem_we   = 1'b1;
          tbl_wr.addr     = cmp_idx_r;
          tbl_wr.rem_data = diff;
          pend_grant_nxt  = 1'b1;
          pend_block_nxt  = cmp_idx_r;
          pend_cap_nxt    = orig_q;
          pend_left_nxt   = diff;
          state_nxt       = ffba_pkg::ST_DONE;
        end else if (fin_miss) begin
          pend_grant_nxt = 1'b0;
          pend_block_nxt = '0;
          pend_cap_nxt   = '0;
          pend_left_nxt  = '0;
          state_nxt      = ffba_pkg::ST_DONE;
        end else begin
          // The read issued now is checked in the next cycle.
          cmp_vld_nxt = (rd_idx_r < limit_r);
          cmp_idx_nxt = rd_idx_r[IDX-1:0];
          if (rd_idx_r < limit_r) begin
            rd_idx_nxt = rd_idx_r + USE'(1);
          end
        end
      end

      ffba_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_grant_nxt = pend_grant_r;
          out_block_nxt = pend_block_r;
          out_cap_nxt   = pend_cap_r;
          out_left_nxt  = pend_left_r;
          state_nxt     = ffba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ffba_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    limit_r      <= limit_nxt;
    req_r        <= req_nxt;
    pend_grant_r <= pend_grant_nxt;
    pend_block_r <= pend_block_nxt;
    pend_cap_r   <= pend_cap_nxt;
    pend_left_r  <= pend_left_nxt;
    out_grant_r  <= out_grant_nxt;
    out_block_r  <= out_block_nxt;
    out_cap_r    <= out_cap_nxt;
    out_left_r   <= out_left_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_grant_r;
  assign out_tdata  = {{(ffba_pkg::OUT_DATA_BITS - IDX - 2 * SZ){1'b0}},
                       out_left_r, out_cap_r, out_block_r};

endmodule
